// File: hdl/lzp_pkg.sv
// Shared constants, codes and struct types for the palette LZSS pixel decoder.
// No dependencies; compiled first.
package lzp_pkg;

    localparam int WINDOW_DEPTH  = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
    localparam int PTR_XW        = WIN_AW + 1;        // holds WINDOW_DEPTH itself
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int DIST_W        = 13;                // 12-bit offset plus one
    localparam int CNT_W         = 5;                 // nibble plus three

    localparam logic [WIN_AW-1:0] WIN_LAST   = WIN_AW'(WINDOW_DEPTH - 1);
    localparam logic [PTR_XW-1:0] WIN_SIZE_X = PTR_XW'(WINDOW_DEPTH);
    localparam logic [7:0]        SIGNATURE  = 8'hF0;
    localparam logic [5:0]        FLAG_BITS  = 6'd32;
    localparam logic [CNT_W-1:0]  COUNT_BIAS = CNT_W'(3);

    // operation codes
    localparam logic [1:0] OP_PAL_LOAD     = 2'd0;
    localparam logic [1:0] OP_STREAM_BYTE  = 2'd1;
    localparam logic [1:0] OP_STREAM_START = 2'd2;

    typedef struct packed {
        logic [15:0] pixel;
        logic        sig_err;
        logic        last;
    } t_result;

    typedef struct packed {
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [15:0]       wr_data;
    } t_hist_port;

    typedef struct packed {
        logic              rd_en;
        logic [PAL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [PAL_AW-1:0] wr_addr;
        logic [15:0]       wr_data;
    } t_pal_port;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } t_fifo_stat;

endpackage

// File: hdl/lzp_stream_if.sv
// Valid/ready channel interfaces: input words and result words.
// No dependencies.
interface lzp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [15:0] color;

    modport source (output valid, operation, data_byte, color, input ready);
    modport sink   (input valid, operation, data_byte, color, output ready);
endinterface

interface lzp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        signature_error;
    logic        last_of_run;

    modport source (output valid, pixel, signature_error, last_of_run, input ready);
    modport sink   (input valid, pixel, signature_error, last_of_run, output ready);
endinterface

// File: hdl/lzp_pal_ram.sv
// 256 x 16 palette RAM, one write and one registered read port.
// Uses lzp_pkg.
module lzp_pal_ram (
    input  logic                i_clk,
    input  lzp_pkg::t_pal_port  i_port,
    output logic [15:0]         o_rdata
);
    import lzp_pkg::*;

    logic [15:0] r_mem [PALETTE_DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_port.wr_en) begin
            r_mem[i_port.wr_addr] <= i_port.wr_data;
        end
        if (i_port.rd_en) begin
            r_rdata <= r_mem[i_port.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lzp_hist_ram.sv
// History window RAM with write-to-read forwarding on a same-address collision.
// Uses lzp_pkg.
module lzp_hist_ram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lzp_pkg::t_hist_port i_port,
    output logic [15:0]         o_rdata
);
    import lzp_pkg::*;

    logic [15:0] r_mem [WINDOW_DEPTH];
    logic [15:0] r_rdata;
    logic [15:0] r_fwd_data;
    logic        r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_port.wr_en) begin
            r_mem[i_port.wr_addr] <= i_port.wr_data;
        end
        if (i_port.rd_en) begin
            r_rdata <= r_mem[i_port.rd_addr];
        end
        r_fwd_data <= i_port.wr_data;
    end

    // distance-one copies read the entry being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_port.rd_en) begin
            r_fwd <= i_port.wr_en && (i_port.wr_addr == i_port.rd_addr);
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;

endmodule

// File: hdl/lzp_out_fifo.sv
// Two-word result queue that parts the decoder from the output channel.
// Uses lzp_pkg.
module lzp_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lzp_pkg::t_result    i_data,
    input  logic                i_ready,
    output logic                o_valid,
    output lzp_pkg::t_result    o_data,
    output lzp_pkg::t_fifo_stat o_stat
);
    import lzp_pkg::*;

    t_result    r_mem [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];
    assign o_stat  = '{count: r_count, pop: pop};

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// File: hdl/lzp_ctrl.sv
// Stream parser and copy sequencer: drives both RAMs and pushes result words.
// Uses lzp_pkg.
module lzp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_byte,
    input  logic [15:0]         i_color,
    output logic                o_ready,
    input  lzp_pkg::t_fifo_stat i_fifo,
    output logic                o_push,
    output lzp_pkg::t_result    o_push_data,
    output lzp_pkg::t_hist_port o_hist,
    input  logic [15:0]         i_hist_rdata,
    output lzp_pkg::t_pal_port  o_pal,
    input  logic [15:0]         i_pal_rdata
);
    import lzp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_BOUNDARY,
        PH_FLAGS,
        PH_LITERAL,
        PH_TOKEN
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [1:0]        r_bpos, n_bpos;
    logic [31:0]       r_gather, n_gather;
    logic [31:0]       r_flags, n_flags;
    logic [5:0]        r_frem, n_frem;
    logic              r_halt, n_halt;
    logic [WIN_AW-1:0] r_wp, n_wp;
    logic [PTR_XW-1:0] r_fill, n_fill;
    logic              r_copying, n_copying;
    logic [WIN_AW-1:0] r_src, n_src;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_pend_pal, n_pend_pal;
    logic              r_pend_hist, n_pend_hist;
    logic              r_pend_err, n_pend_err;
    logic              r_pend_zero, n_pend_zero;
    logic              r_pend_last, n_pend_last;
    logic [WIN_AW-1:0] r_pend_addr, n_pend_addr;

    logic              pend_any;
    logic              issue_ok;
    logic [31:0]       gathered;
    logic [WIN_AW-1:0] wp_inc;
    logic [WIN_AW-1:0] src_inc;
    logic [PTR_XW-1:0] fill_inc;
    logic [DIST_W-1:0] tok_dist;
    logic [PTR_XW-1:0] wp_x;
    logic [PTR_XW-1:0] dist_x;
    logic [WIN_AW-1:0] src_start;
    logic [15:0]       pix;

    assign pend_any = r_pend_pal || r_pend_hist || r_pend_err;
    // room in the queue for queued + in-flight + one more, counting this cycle's pop
    assign issue_ok = ({1'b0, i_fifo.count} + {2'b00, pend_any})
                      < (3'd2 + {2'b00, i_fifo.pop});
    assign o_ready  = !r_copying && !pend_any && (i_fifo.count != 2'd2);

    assign gathered = r_gather | (32'(i_byte) << {r_bpos, 3'b000});
    assign wp_inc   = (r_wp == WIN_LAST) ? '0 : r_wp + 1'b1;
    assign src_inc  = (r_src == WIN_LAST) ? '0 : r_src + 1'b1;
    assign fill_inc = (r_fill == WIN_SIZE_X) ? r_fill : r_fill + 1'b1;
    assign tok_dist = {1'b0, i_byte[3:0], r_gather[7:0]} + DIST_W'(1);
    assign wp_x     = {1'b0, r_wp};
    assign dist_x   = PTR_XW'(tok_dist);
    assign src_start = (wp_x >= dist_x) ? WIN_AW'(wp_x - dist_x)
                                        : WIN_AW'(wp_x + WIN_SIZE_X - dist_x);
    assign pix = r_pend_pal  ? i_pal_rdata :
                 r_pend_zero ? 16'h0000 : i_hist_rdata;

    always_comb begin
        n_phase     = r_phase;
        n_bpos      = r_bpos;
        n_gather    = r_gather;
        n_flags     = r_flags;
        n_frem      = r_frem;
        n_halt      = r_halt;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_copying   = r_copying;
        n_src       = r_src;
        n_left      = r_left;
        n_dist      = r_dist;
        n_pend_pal  = 1'b0;
        n_pend_hist = 1'b0;
        n_pend_err  = 1'b0;
        n_pend_zero = 1'b0;
        n_pend_last = 1'b0;
        n_pend_addr = r_pend_addr;
        o_push      = 1'b0;
        o_push_data = '0;
        o_hist      = '0;
        o_pal       = '0;

        // read data lands: push the word, record the pixel in history; or push an error word
        if (r_pend_pal || r_pend_hist) begin
            o_push         = 1'b1;
            o_push_data    = '{pixel: pix, sig_err: 1'b0, last: r_pend_last};
            o_hist.wr_en   = 1'b1;
            o_hist.wr_addr = r_pend_addr;
            o_hist.wr_data = pix;
        end else if (r_pend_err) begin
            o_push      = 1'b1;
            o_push_data = '{pixel: 16'h0000, sig_err: 1'b1, last: 1'b0};
        end

        // copy run, one history read per cycle while the queue has room
        if (r_copying && issue_ok) begin
            o_hist.rd_en   = 1'b1;
            o_hist.rd_addr = r_src;
            n_pend_hist    = 1'b1;
            n_pend_zero    = PTR_XW'(r_dist) > r_fill;   // not yet written since start
            n_pend_last    = (r_left == CNT_W'(1));
            n_pend_addr    = r_wp;
            n_wp           = wp_inc;
            n_fill         = fill_inc;
            n_src          = src_inc;
            n_left         = r_left - 1'b1;
            if (r_left == CNT_W'(1)) begin
                n_copying = 1'b0;
            end
        end

        if (i_acc) begin
            case (i_op)
                OP_PAL_LOAD: begin
                    o_pal.wr_en   = 1'b1;
                    o_pal.wr_addr = i_byte[PAL_AW-1:0];
                    o_pal.wr_data = i_color;
                end
                OP_STREAM_BYTE: begin
                    if (!r_halt) begin
                        case (r_phase)
                            PH_HEADER: begin
                                n_gather = gathered;
                                if (r_bpos == 2'd3) begin
                                    n_bpos = 2'd0;
                                    if (gathered[7:0] != SIGNATURE) begin
                                        n_halt     = 1'b1;
                                        n_pend_err = 1'b1;
                                    end else begin
                                        n_gather = '0;
                                        n_phase  = PH_BOUNDARY;
                                    end
                                end else begin
                                    n_bpos = r_bpos + 1'b1;
                                end
                            end
                            PH_FLAGS: begin
                                n_gather = gathered;
                                if (r_bpos == 2'd3) begin
                                    n_bpos   = 2'd0;
                                    n_flags  = gathered;
                                    n_gather = '0;
                                    n_frem   = FLAG_BITS;
                                    n_phase  = PH_BOUNDARY;
                                end else begin
                                    n_bpos = r_bpos + 1'b1;
                                end
                            end
                            PH_LITERAL: begin
                                o_pal.rd_en   = 1'b1;
                                o_pal.rd_addr = i_byte[PAL_AW-1:0];
                                n_pend_pal    = 1'b1;
                                n_pend_last   = 1'b1;
                                n_pend_addr   = r_wp;
                                n_wp          = wp_inc;
                                n_fill        = fill_inc;
                                n_phase       = PH_BOUNDARY;
                            end
                            PH_TOKEN: begin
                                n_gather  = '0;
                                n_bpos    = 2'd0;
                                n_copying = 1'b1;
                                n_left    = {1'b0, i_byte[7:4]} + COUNT_BIAS;
                                n_dist    = tok_dist;
                                n_src     = src_start;
                                n_phase   = PH_BOUNDARY;
                            end
                            PH_BOUNDARY: begin
                                if (r_frem == 6'd0) begin
                                    // byte opens the next flag word
                                    n_gather = {24'h000000, i_byte};
                                    n_bpos   = 2'd1;
                                    n_phase  = PH_FLAGS;
                                end else begin
                                    n_flags = r_flags << 1;
                                    n_frem  = r_frem - 1'b1;
                                    if (!r_flags[31]) begin
                                        o_pal.rd_en   = 1'b1;
                                        o_pal.rd_addr = i_byte[PAL_AW-1:0];
                                        n_pend_pal    = 1'b1;
                                        n_pend_last   = 1'b1;
                                        n_pend_addr   = r_wp;
                                        n_wp          = wp_inc;
                                        n_fill        = fill_inc;
                                        n_phase       = PH_LITERAL;
                                    end else begin
                                        n_gather = {24'h000000, i_byte};
                                        n_bpos   = 2'd1;
                                        n_phase  = PH_TOKEN;
                                    end
                                end
                            end
                            default: begin
                                n_phase = PH_HEADER;
                            end
                        endcase
                    end
                end
                OP_STREAM_START: begin
                    n_phase  = PH_HEADER;
                    n_bpos   = 2'd0;
                    n_gather = '0;
                    n_flags  = '0;
                    n_frem   = 6'd0;
                    n_halt   = 1'b0;
                    n_wp     = '0;
                    n_fill   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_bpos      <= 2'd0;
            r_gather    <= '0;
            r_flags     <= '0;
            r_frem      <= 6'd0;
            r_halt      <= 1'b0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_copying   <= 1'b0;
            r_left      <= '0;
            r_pend_pal  <= 1'b0;
            r_pend_hist <= 1'b0;
            r_pend_err  <= 1'b0;
            r_pend_zero <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bpos      <= n_bpos;
            r_gather    <= n_gather;
            r_flags     <= n_flags;
            r_frem      <= n_frem;
            r_halt      <= n_halt;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_copying   <= n_copying;
            r_left      <= n_left;
            r_pend_pal  <= n_pend_pal;
            r_pend_hist <= n_pend_hist;
            r_pend_err  <= n_pend_err;
            r_pend_zero <= n_pend_zero;
            r_pend_last <= n_pend_last;
        end
        r_src       <= n_src;
        r_dist      <= n_dist;
        r_pend_addr <= n_pend_addr;
    end

endmodule

// File: hdl/lzss_palette_pixel_decoder.sv
// Top level of the palette LZSS pixel decoder: parser, history and palette RAMs,
// output queue. Uses lzp_pkg, lzp_stream_if and the lzp_* submodules.
//
// Feed palette loads, stream starts and compressed bytes on i_in; 16-bit pixels
// come out on o_out, last_of_run marking the final pixel that a byte caused.
// A palette load, a stream start, and a header or flag-word byte leave the
// input ready again in the cycle after; a fourth header byte that fails the
// signature check holds the input until its error word has landed. A literal
// byte reads the palette RAM, then its pixel word is pushed. A copy token
// gives k pixels (3 to 18): the history RAM has one read port, so the copy
// sequencer reads one pixel per cycle while the output queue has room, and
// the next byte is taken once the last pixel has landed.
// Results wait in a two-word queue, so input is still taken while a finished
// word waits to be read. A stream start empties the history window at once:
// a fill count marks how much of the window holds pixels of this stream, and a
// copy reaching further back gives zero, so there is no clearing pass after
// reset or start. The palette survives a start; unwritten entries are
// undefined. A bad header signature gives one word with signature_error set,
// then stream bytes are dropped until the next start.
module lzss_palette_pixel_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lzp_in_if.sink           i_in,
    lzp_out_if.source        o_out
);
    import lzp_pkg::*;

    logic       acc;
    logic       ready;
    t_fifo_stat fifo_stat;
    logic       push;
    t_result    push_data;
    t_result    out_data;
    logic       out_valid;
    t_hist_port hist_port;
    t_pal_port  pal_port;
    logic [15:0] hist_rdata;
    logic [15:0] pal_rdata;

    // a word moves on valid && ready
    assign acc        = i_in.valid && ready;
    assign i_in.ready = ready;

    lzp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_op         (i_in.operation),
        .i_byte       (i_in.data_byte),
        .i_color      (i_in.color),
        .o_ready      (ready),
        .i_fifo       (fifo_stat),
        .o_push       (push),
        .o_push_data  (push_data),
        .o_hist       (hist_port),
        .i_hist_rdata (hist_rdata),
        .o_pal        (pal_port),
        .i_pal_rdata  (pal_rdata)
    );

    lzp_hist_ram u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_port  (hist_port),
        .o_rdata (hist_rdata)
    );

    lzp_pal_ram u_pal (
        .i_clk   (i_clk),
        .i_port  (pal_port),
        .o_rdata (pal_rdata)
    );

    lzp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_ready (o_out.ready),
        .o_valid (out_valid),
        .o_data  (out_data),
        .o_stat  (fifo_stat)
    );

    assign o_out.valid           = out_valid;
    assign o_out.pixel           = out_data.pixel;
    assign o_out.signature_error = out_data.sig_err;
    assign o_out.last_of_run     = out_data.last;

endmodule

// File: hdl/lzp_checker.sv
// Port-level checks for the decoder, attached by the bind at the end.
// Uses lzp_pkg; binds to lzss_palette_pixel_decoder.
module lzp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_operation,
    input logic        o_out_valid,
    input logic        o_out_ready,
    input logic [15:0] o_out_pixel,
    input logic        o_out_signature_error,
    input logic        o_out_last_of_run
);
    import lzp_pkg::*;

    // error word carries no pixel and never ends a run
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_signature_error |-> (o_out_pixel == 16'h0000)
                                                 && !o_out_last_of_run)
        else $error("signature error word with pixel or last set");

    // words other than stream bytes leave the input open next cycle
    a_no_pixel_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_operation != OP_STREAM_BYTE)
        |=> i_in_ready)
        else $error("input not ready after a non-stream word");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> $stable(o_out_pixel)
                                        && $stable(o_out_signature_error)
                                        && $stable(o_out_last_of_run))
        else $error("output word changed while stalled");

endmodule

bind lzss_palette_pixel_decoder lzp_checker u_lzp_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in.valid),
    .i_in_ready            (i_in.ready),
    .i_in_operation        (i_in.operation),
    .o_out_valid           (o_out.valid),
    .o_out_ready           (o_out.ready),
    .o_out_pixel           (o_out.pixel),
    .o_out_signature_error (o_out.signature_error),
    .o_out_last_of_run     (o_out.last_of_run)
);
